### rtl/pru_pkg.sv
// shared constants, types and the paeth helper for the png rgba8 unfilter block
// no dependencies; used by every other file of the block except pru_if
package pru_pkg;

    // line store geometry
    localparam int MAX_ROW_PIXELS = 4096;
    localparam int CHANNELS       = 4;
    localparam int COL_W          = $clog2(MAX_ROW_PIXELS);
    localparam int WIDTH_W        = 13;
    localparam int PIXEL_W        = 8 * CHANNELS;

    // configuration port
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;
    localparam logic REG_ROW_WIDTH = 1'b0;

    // filter type codes
    localparam logic [2:0] FILT_NONE    = 3'd0;
    localparam logic [2:0] FILT_SUB     = 3'd1;
    localparam logic [2:0] FILT_UP      = 3'd2;
    localparam logic [2:0] FILT_AVERAGE = 3'd3;
    localparam logic [2:0] FILT_PAETH   = 3'd4;

    typedef logic [COL_W-1:0]   t_col;
    typedef logic [PIXEL_W-1:0] t_pixel;

    // line store read request
    typedef struct packed {
        logic en;
        t_col addr;
    } t_ls_rd;

    // line store write request
    typedef struct packed {
        logic   en;
        t_col   addr;
        t_pixel data;
    } t_ls_wr;

    // paeth chooser on one channel: a left, b above, c upper-left
    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic [9:0] pa;
        logic [9:0] pb;
        logic [9:0] pc;
        logic [9:0] ab;
        logic [9:0] cc;
        pa = (b > c) ? {2'b00, b - c} : {2'b00, c - b};
        pb = (a > c) ? {2'b00, a - c} : {2'b00, c - a};
        ab = {2'b00, a} + {2'b00, b};
        cc = {1'b0, c, 1'b0};
        pc = (ab > cc) ? ab - cc : cc - ab;
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end else begin
            return c;
        end
    endfunction

endpackage

### rtl/pru_if.sv
// stream interfaces for filtered input words and reconstructed output words
// depends on nothing but plain logic types
interface pru_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] filter_type;
    logic       first_row;
    logic [7:0] raw_red;
    logic [7:0] raw_green;
    logic [7:0] raw_blue;
    logic [7:0] raw_alpha;

    modport source (output valid, filter_type, first_row, raw_red, raw_green, raw_blue,
                    raw_alpha, input ready);
    modport sink (input valid, filter_type, first_row, raw_red, raw_green, raw_blue,
                  raw_alpha, output ready);
endinterface

interface pru_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       end_of_row;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, end_of_row,
                    input ready);
    modport sink (input valid, out_red, out_green, out_blue, out_alpha, end_of_row,
                  output ready);
endinterface

### rtl/pru_line_store.sv
// previous-row line store: one write port, one registered read port
// depends on pru_pkg for geometry and request structs
module pru_line_store (
    input  logic            i_clk,
    input  pru_pkg::t_ls_rd i_rd,
    input  pru_pkg::t_ls_wr i_wr,
    output pru_pkg::t_pixel o_rd_data
);

    pru_pkg::t_pixel mem [pru_pkg::MAX_ROW_PIXELS];
    pru_pkg::t_pixel r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read port, data held between reads
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/pru_predict.sv
// per-channel predictor and modulo-256 add for one rgba pixel
// depends on pru_pkg for filter codes and the paeth function
module pru_predict (
    input  logic [2:0]      i_filt,
    input  pru_pkg::t_pixel i_raw,
    input  pru_pkg::t_pixel i_left,
    input  pru_pkg::t_pixel i_above,
    input  pru_pkg::t_pixel i_upleft,
    output pru_pkg::t_pixel o_result
);

    // one lane per channel
    always_comb begin
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [7:0] pred;
        logic [8:0] sum;
        o_result = '0;
        for (int ch = 0; ch < pru_pkg::CHANNELS; ch++) begin
            a   = i_left[8*ch +: 8];
            b   = i_above[8*ch +: 8];
            c   = i_upleft[8*ch +: 8];
            sum = {1'b0, a} + {1'b0, b};
            unique case (i_filt)
                pru_pkg::FILT_SUB:     pred = a;
                pru_pkg::FILT_UP:      pred = b;
                pru_pkg::FILT_AVERAGE: pred = sum[8:1];
                pru_pkg::FILT_PAETH:   pred = pru_pkg::paeth(a, b, c);
                default:               pred = 8'd0;
            endcase
            o_result[8*ch +: 8] = i_raw[8*ch +: 8] + pred;
        end
    end

endmodule

### rtl/png_rgba8_unfilter_core.sv
// Reconstructs filtered png scanlines of 8-bit rgba pixels at one pixel word per
// clock cycle sustained while the output keeps ready high; an accepted word passes
// through the stage-one register and then the output register. The above pixel is
// read from the line store in the cycle a word is accepted and used while that word
// sits in stage one, where the left-pixel add chain closes; a store write and a read
// of the same column at the same edge is forwarded. Program row_width (register at
// byte address 0) only while idle.
// The filter type is taken from column 0 of each row; codes 5 to 7 pass through.
// depends on pru_pkg, pru_if, pru_line_store and pru_predict
module png_rgba8_unfilter_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pru_in_if.sink                         i_pix,
    pru_out_if.source                      o_pix,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pru_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pru_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pru_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam logic [pru_pkg::WIDTH_W-1:0] MaxWidth = pru_pkg::WIDTH_W'(pru_pkg::MAX_ROW_PIXELS);

    logic [pru_pkg::WIDTH_W-1:0] r_row_width;
    pru_pkg::t_col               r_col;
    logic [2:0]                  r_row_filter;

    logic            r_s1_v;
    pru_pkg::t_pixel r_s1_raw;
    logic [2:0]      r_s1_filt;
    logic            r_s1_first;
    logic            r_s1_col0;
    logic            r_s1_last;
    pru_pkg::t_col   r_s1_col;
    logic            r_fwd;
    pru_pkg::t_pixel r_fwd_data;

    pru_pkg::t_pixel r_left;
    pru_pkg::t_pixel r_upleft;

    logic            r_out_v;
    pru_pkg::t_pixel r_out_pix;
    logic            r_out_last;

    logic                        accept;
    logic                        s1_adv;
    logic [pru_pkg::WIDTH_W-1:0] width_eff;
    logic [pru_pkg::WIDTH_W-1:0] col_next;
    logic                        col_last;
    logic [2:0]                  filt_cur;
    pru_pkg::t_pixel             rd_data;
    pru_pkg::t_pixel             above;
    pru_pkg::t_pixel             left;
    pru_pkg::t_pixel             upleft;
    pru_pkg::t_pixel             result;
    pru_pkg::t_ls_rd             ls_rd;
    pru_pkg::t_ls_wr             ls_wr;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == pru_pkg::REG_ROW_WIDTH)
                  ? {{(pru_pkg::APB_DATA_W - pru_pkg::WIDTH_W){1'b0}}, r_row_width} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= pru_pkg::WIDTH_W'(1);
        end else if (psel && penable && pwrite && paddr[2] == pru_pkg::REG_ROW_WIDTH) begin
            r_row_width <= pwdata[pru_pkg::WIDTH_W-1:0];
        end
    end

    // handshake between input, stage one and the output register
    assign s1_adv      = r_s1_v && (!r_out_v || o_pix.ready);
    assign i_pix.ready = !r_s1_v || s1_adv;
    assign accept      = i_pix.valid && i_pix.ready;

    // column tracking and row end at acceptance
    always_comb begin
        if (r_row_width == '0) begin
            width_eff = pru_pkg::WIDTH_W'(1);
        end else if (r_row_width > MaxWidth) begin
            width_eff = MaxWidth;
        end else begin
            width_eff = r_row_width;
        end
        col_next = {1'b0, r_col} + pru_pkg::WIDTH_W'(1);
        col_last = col_next >= width_eff;
        filt_cur = (r_col == '0) ? i_pix.filter_type : r_row_filter;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row_filter <= pru_pkg::FILT_NONE;
        end else if (accept) begin
            r_col        <= col_last ? '0 : col_next[pru_pkg::COL_W-1:0];
            r_row_filter <= filt_cur;
        end
    end

    // line store read issued at acceptance
    assign ls_rd.en   = accept;
    assign ls_rd.addr = r_col;

    // stage one register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_fwd  <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_v <= 1'b1;
                r_fwd  <= s1_adv && (r_s1_col == r_col);
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_raw   <= {i_pix.raw_alpha, i_pix.raw_blue, i_pix.raw_green, i_pix.raw_red};
            r_s1_filt  <= filt_cur;
            r_s1_first <= i_pix.first_row;
            r_s1_col0  <= (r_col == '0);
            r_s1_last  <= col_last;
            r_s1_col   <= r_col;
            r_fwd_data <= result;
        end
    end

    pru_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rd      (ls_rd),
        .i_wr      (ls_wr),
        .o_rd_data (rd_data)
    );

    // neighbor selection with forwarding of a same-column write
    always_comb begin
        if (r_s1_first) begin
            above = '0;
        end else if (r_fwd) begin
            above = r_fwd_data;
        end else begin
            above = rd_data;
        end
        left   = r_s1_col0 ? '0 : r_left;
        upleft = (r_s1_col0 || r_s1_first) ? '0 : r_upleft;
    end

    pru_predict u_predict (
        .i_filt   (r_s1_filt),
        .i_raw    (r_s1_raw),
        .i_left   (left),
        .i_above  (above),
        .i_upleft (upleft),
        .o_result (result)
    );

    // write back the reconstructed pixel
    assign ls_wr.en   = s1_adv;
    assign ls_wr.addr = r_s1_col;
    assign ls_wr.data = result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_upleft <= '0;
        end else if (s1_adv) begin
            r_left   <= result;
            r_upleft <= above;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s1_adv) begin
            r_out_v <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_pix  <= result;
            r_out_last <= r_s1_last;
        end
    end

    assign o_pix.valid      = r_out_v;
    assign o_pix.out_red    = r_out_pix[7:0];
    assign o_pix.out_green  = r_out_pix[15:8];
    assign o_pix.out_blue   = r_out_pix[23:16];
    assign o_pix.out_alpha  = r_out_pix[31:24];
    assign o_pix.end_of_row = r_out_last;

endmodule

### dv/tb_top.sv
// self-checking bench for png_rgba8_unfilter_core: scanline rows of rgba words,
// predicted in-bench and checked word by word at the output stream
// depends on pru_pkg, pru_if and the core rtl
`timescale 1ns / 100ps

module tb_top;
    import pru_pkg::*;

    localparam int unsigned WATCHDOG_CYCLES = 6000;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned HOLD_CYCLES     = 300;
    localparam int unsigned MAX_REPORTS     = 10;
    localparam int unsigned NO_CAP          = 32'h00FF_FFFF;
    localparam int unsigned RANDOM_WORDS    = 1150;

    // codes outside the defined filter set, which pass bytes through
    localparam logic [2:0] FILT_RSVD_LO = 3'd5;
    localparam logic [2:0] FILT_RSVD_HI = 3'd7;

    localparam logic [APB_ADDR_W-1:0] ROW_WIDTH_ADDR = APB_ADDR_W'(4 * REG_ROW_WIDTH);

    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill;

    typedef struct packed {
        logic [2:0] filter_type;
        logic       first_row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_raw_word;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       end_of_row;
    } t_recon_word;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pru_in_if  pix_in ();
    pru_out_if pix_out ();

    png_rgba8_unfilter_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the block state
    t_pixel             line_shadow [MAX_ROW_PIXELS];
    bit                 line_written [MAX_ROW_PIXELS];
    t_pixel             left_shadow;
    t_pixel             upleft_shadow;
    int unsigned        col_shadow;
    logic [2:0]         filter_shadow;
    logic [WIDTH_W-1:0] row_width_shadow;

    t_recon_word recon_due_q[$];
    int unsigned fail_count;
    int unsigned report_count;
    bit          tx_gaps;
    bit          rx_gaps;
    bit          rx_hold;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned active_width();
        if (row_width_shadow == 0) begin
            return 1;
        end
        if (row_width_shadow > MAX_ROW_PIXELS) begin
            return MAX_ROW_PIXELS;
        end
        return row_width_shadow;
    endfunction

    // pick the neighbor closest to left + above - upper-left
    function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        int est;
        int da;
        int db;
        int dc;
        est = int'(a) + int'(b) - int'(c);
        da  = (est > int'(a)) ? est - int'(a) : int'(a) - est;
        db  = (est > int'(b)) ? est - int'(b) : int'(b) - est;
        dc  = (est > int'(c)) ? est - int'(c) : int'(c) - est;
        if (da <= db && da <= dc) begin
            return a;
        end else if (db <= dc) begin
            return b;
        end
        return c;
    endfunction

    // reconstruct one accepted word and advance the shadow state
    function automatic t_recon_word reconstruct_pixel(t_raw_word w);
        int unsigned col;
        t_pixel      above;
        t_pixel      left;
        t_pixel      upleft;
        t_pixel      recon;
        logic [7:0]  raw_b [4];
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  pred;
        logic [8:0]  sum;
        t_recon_word r;
        col = col_shadow;
        if (col == 0) begin
            filter_shadow = w.filter_type;
        end
        above  = w.first_row ? '0 : line_shadow[col];
        left   = (col == 0) ? '0 : left_shadow;
        upleft = (col == 0 || w.first_row) ? '0 : upleft_shadow;
        raw_b  = '{w.red, w.green, w.blue, w.alpha};
        for (int ch = 0; ch < CHANNELS; ch++) begin
            a   = left[8*ch +: 8];
            b   = above[8*ch +: 8];
            c   = upleft[8*ch +: 8];
            sum = {1'b0, a} + {1'b0, b};
            case (filter_shadow)
                FILT_SUB:     pred = a;
                FILT_UP:      pred = b;
                FILT_AVERAGE: pred = sum[8:1];
                FILT_PAETH:   pred = paeth_pick(a, b, c);
                default:      pred = 8'h00;
            endcase
            recon[8*ch +: 8] = raw_b[ch] + pred;
        end
        line_shadow[col]  = recon;
        line_written[col] = 1'b1;
        left_shadow       = recon;
        upleft_shadow     = above;
        r.red        = recon[7:0];
        r.green      = recon[15:8];
        r.blue       = recon[23:16];
        r.alpha      = recon[31:24];
        r.end_of_row = (col + 1 >= active_width());
        col_shadow   = r.end_of_row ? 0 : col + 1;
        return r;
    endfunction

    function automatic logic [7:0] pick_byte(t_fill fill);
        int unsigned r;
        r = $urandom_range(0, 9);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
        endcase
    endfunction

    // above data is claimed only for columns the line store already holds
    function automatic t_raw_word make_word(logic [2:0] row_filter, bit want_first, t_fill fill);
        t_raw_word w;
        w.filter_type = (col_shadow == 0) ? row_filter : 3'($urandom_range(0, 7));
        w.first_row   = want_first || !line_written[col_shadow];
        w.red         = pick_byte(fill);
        w.green       = pick_byte(fill);
        w.blue        = pick_byte(fill);
        w.alpha       = pick_byte(fill);
        return w;
    endfunction

    function automatic logic [2:0] pick_filter();
        if ($urandom_range(0, 9) == 0) begin
            return 3'($urandom_range(FILT_RSVD_LO, FILT_RSVD_HI));
        end
        return 3'($urandom_range(FILT_NONE, FILT_PAETH));
    endfunction

    // offer one word and log its prediction once it is taken
    task automatic send_word(t_raw_word w);
        int unsigned gap;
        gap = tx_gaps ? $urandom_range(0, 3) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_in.valid       <= 1'b1;
        pix_in.filter_type <= w.filter_type;
        pix_in.first_row   <= w.first_row;
        pix_in.raw_red     <= w.red;
        pix_in.raw_green   <= w.green;
        pix_in.raw_blue    <= w.blue;
        pix_in.raw_alpha   <= w.alpha;
        do @(posedge i_clk); while (pix_in.ready !== 1'b1);
        recon_due_q.push_back(reconstruct_pixel(w));
    endtask

    // send words until the row closes or the cap is hit
    task automatic send_row(input logic [2:0] row_filter, input bit want_first,
                            input t_fill fill, input int unsigned cap, input bit noisy,
                            output int unsigned sent);
        bit first_now;
        sent = 0;
        do begin
            first_now = noisy ? bit'($urandom_range(0, 1)) : want_first;
            send_word(make_word(row_filter, first_now, fill));
            sent++;
        end while (col_shadow != 0 && sent < cap);
    endtask

    task automatic wait_drained();
        while (recon_due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write once the pipe is empty
    task automatic write_row_width(int unsigned value);
        @(negedge i_clk);
        pix_in.valid <= 1'b0;
        wait_drained();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ROW_WIDTH_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        row_width_shadow = WIDTH_W'(value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // every filter, byte extremes, reserved codes, first_row flipping mid-row
    task automatic test_filter_basics();
        int unsigned n;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        write_row_width(3);
        send_row(FILT_NONE,    1'b1, FILL_ONES,   NO_CAP, 1'b0, n);
        send_row(FILT_SUB,     1'b1, FILL_ONES,   NO_CAP, 1'b0, n);
        send_row(FILT_UP,      1'b0, FILL_ONES,   NO_CAP, 1'b0, n);
        send_row(FILT_AVERAGE, 1'b0, FILL_ONES,   NO_CAP, 1'b0, n);
        send_row(FILT_PAETH,   1'b0, FILL_RANDOM, NO_CAP, 1'b0, n);
        send_row(FILT_PAETH,   1'b0, FILL_ZERO,   NO_CAP, 1'b0, n);
        send_row(FILT_RSVD_HI, 1'b0, FILL_ZERO,   NO_CAP, 1'b0, n);
        send_word(make_word(FILT_RSVD_LO, 1'b0, FILL_RANDOM));
        send_word(make_word(FILT_RSVD_LO, 1'b1, FILL_RANDOM));
        send_word(make_word(FILT_RSVD_LO, 1'b0, FILL_RANDOM));
    endtask

    // zero width, oversize width, width changed inside a row
    task automatic test_width_limits();
        int unsigned n;
        write_row_width(0);
        send_row(FILT_SUB, 1'b0, FILL_RANDOM, NO_CAP, 1'b0, n);
        send_row(FILT_UP, 1'b0, FILL_RANDOM, NO_CAP, 1'b0, n);
        send_row(FILT_PAETH, 1'b0, FILL_RANDOM, NO_CAP, 1'b0, n);
        write_row_width(1);
        send_row(FILT_AVERAGE, 1'b0, FILL_RANDOM, NO_CAP, 1'b0, n);
        send_row(FILT_UP, 1'b0, FILL_RANDOM, NO_CAP, 1'b0, n);
        // shrink below the current column: next word ends the row
        write_row_width(8191);
        send_row(FILT_SUB, 1'b0, FILL_RANDOM, 6, 1'b0, n);
        write_row_width(4);
        send_row(FILT_SUB, 1'b0, FILL_RANDOM, NO_CAP, 1'b0, n);
        // shrink but stay beyond the current column
        write_row_width(20);
        send_row(FILT_AVERAGE, 1'b0, FILL_RANDOM, 3, 1'b0, n);
        write_row_width(10);
        send_row(FILT_AVERAGE, 1'b0, FILL_RANDOM, NO_CAP, 1'b0, n);
        // oversize width clamps to the line store depth, row goes on
        write_row_width(4097);
        send_row(FILT_PAETH, 1'b0, FILL_RANDOM, 6, 1'b0, n);
        write_row_width(4096);
        send_row(FILT_UP, 1'b0, FILL_RANDOM, 5, 1'b0, n);
        write_row_width(2);
        send_row(FILT_UP, 1'b0, FILL_RANDOM, NO_CAP, 1'b0, n);
    endtask

    // mostly well-formed images at varied widths, with noisy and cut rows mixed in
    task automatic test_random_images(int unsigned goal);
        int unsigned total;
        int unsigned pick;
        int unsigned w;
        int unsigned rows;
        int unsigned cap;
        int unsigned n;
        bit          fresh;
        total = 0;
        while (total < goal) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                w = 0;
            end else if (pick < 13) begin
                w = $urandom_range(1, 8);
            end else if (pick < 19) begin
                w = $urandom_range(9, 40);
            end else begin
                w = $urandom_range(41, 160);
            end
            write_row_width(w);
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            fresh   = bit'($urandom_range(0, 1));
            rows    = $urandom_range(1, (w > 40) ? 2 : 6);
            for (int r = 0; r < rows; r++) begin
                cap = NO_CAP;
                if (r == rows - 1 && $urandom_range(0, 7) == 0) begin
                    cap = $urandom_range(1, (w > 1) ? w : 1);
                end
                send_row(pick_filter(), fresh && r == 0, FILL_RANDOM, cap,
                         $urandom_range(0, 7) == 0, n);
                total += n;
            end
        end
    endtask

    // output held off long enough for the block to fill and stall its input
    task automatic test_output_hold();
        int unsigned n;
        write_row_width(16);
        tx_gaps = 1'b0;
        rx_gaps = 1'b1;
        fork
            begin
                rx_hold = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold = 1'b0;
            end
        join_none
        for (int r = 0; r < 6; r++) begin
            send_row(pick_filter(), r == 0, FILL_RANDOM, NO_CAP, 1'b0, n);
        end
        tx_gaps = 1'b1;
    endtask

    task automatic check_recon(t_recon_word got);
        t_recon_word want;
        if (recon_due_q.size() == 0) begin
            fail_count++;
            if (report_count < MAX_REPORTS) begin
                report_count++;
                $display("unexpected word: r=%02h g=%02h b=%02h a=%02h eor=%0b",
                         got.red, got.green, got.blue, got.alpha, got.end_of_row);
            end
        end else begin
            want = recon_due_q.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
                got.alpha !== want.alpha || got.end_of_row !== want.end_of_row) begin
                fail_count++;
                if (report_count < MAX_REPORTS) begin
                    report_count++;
                    $display("word mismatch: want r=%02h g=%02h b=%02h a=%02h eor=%0b",
                             want.red, want.green, want.blue, want.alpha, want.end_of_row);
                    $display("                got r=%02h g=%02h b=%02h a=%02h eor=%0b",
                             got.red, got.green, got.blue, got.alpha, got.end_of_row);
                end
            end
        end
    endtask

    // output side: random stalls per word, plus the long hold
    initial begin
        int unsigned k;
        t_recon_word got;
        pix_out.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            k = rx_gaps ? $urandom_range(0, 3) : 0;
            @(negedge i_clk);
            if (k > 0 || rx_hold) begin
                pix_out.ready <= 1'b0;
                repeat (k) @(negedge i_clk);
                while (rx_hold) @(negedge i_clk);
            end
            pix_out.ready <= 1'b1;
            do @(posedge i_clk); while (pix_out.valid !== 1'b1);
            got.red        = pix_out.out_red;
            got.green      = pix_out.out_green;
            got.blue       = pix_out.out_blue;
            got.alpha      = pix_out.out_alpha;
            got.end_of_row = pix_out.end_of_row;
            check_recon(got);
        end
    end

    // watchdog on cycles with no transfer anywhere
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            if ((pix_in.valid === 1'b1 && pix_in.ready === 1'b1) ||
                (pix_out.valid === 1'b1 && pix_out.ready === 1'b1) || psel === 1'b1) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // main sequence
    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        pix_in.valid       = 1'b0;
        pix_in.filter_type = FILT_NONE;
        pix_in.first_row   = 1'b0;
        pix_in.raw_red     = '0;
        pix_in.raw_green   = '0;
        pix_in.raw_blue    = '0;
        pix_in.raw_alpha   = '0;
        for (int i = 0; i < MAX_ROW_PIXELS; i++) begin
            line_shadow[i]  = '0;
            line_written[i] = 1'b0;
        end
        left_shadow      = '0;
        upleft_shadow    = '0;
        col_shadow       = 0;
        filter_shadow    = FILT_NONE;
        row_width_shadow = WIDTH_W'(1);
        fail_count       = 0;
        report_count     = 0;
        tx_gaps          = 1'b1;
        rx_gaps          = 1'b1;
        rx_hold          = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_filter_basics();
        test_width_limits();
        test_output_hold();
        test_random_images(RANDOM_WORDS);

        @(negedge i_clk);
        pix_in.valid <= 1'b0;
        wait_drained();
        if (fail_count == 0 && recon_due_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### png_rgba8_unfilter_core.f
rtl/pru_pkg.sv
rtl/pru_if.sv
rtl/pru_line_store.sv
rtl/pru_predict.sv
rtl/png_rgba8_unfilter_core.sv
dv/tb_top.sv
